@@ hdl/sparse_matrix_coordinate_table_defines.svh @@
// assertion helpers used by the datapath
`ifndef SPARSE_MATRIX_COORDINATE_TABLE_DEFINES_SVH
`define SPARSE_MATRIX_COORDINATE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SMCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SMCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/smct_pkg.sv @@
package smct_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int INDEX_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        REQ_SET = 2'd0,
        REQ_GET = 2'd1,
        REQ_MUL = 2'd2,
        REQ_DIV = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_DIV0  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SC_RD,
        S_SC_LD,
        S_SC_RUN,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    set_status;
        status_t status_code;
        logic    wr_entry;
        logic    scan_start;
        logic    scan;
        logic    take_hit;
        logic    scale_start;
        logic    scale_rd;
        logic    alu_start;
        logic    scale_wr;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t req;
        logic val_zero;
        logic full;
        logic range_err;
        logic count_zero;
        logic hit;
        logic scan_end;
        logic alu_done;
        logic scale_last;
        logic out_busy;
    } sts_t;

endpackage

@@ hdl/smct_in_if.sv @@
interface smct_in_if #(
    parameter int INDEX_BITS = smct_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = smct_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic signed [INDEX_BITS-1:0] row_index;
    logic signed [INDEX_BITS-1:0] col_index;
    logic signed [VALUE_BITS-1:0] operand_value;

    modport source (
        output valid, req_type, row_index, col_index, operand_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_index, col_index, operand_value,
        output ready
    );
endinterface

@@ hdl/smct_out_if.sv @@
interface smct_out_if #(
    parameter int VALUE_BITS = smct_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         found;
    logic [1:0]                   status;

    modport source (
        output valid, read_value, found, status,
        input  ready
    );

    modport sink (
        input  valid, read_value, found, status,
        output ready
    );
endinterface

@@ hdl/smct_alu.sv @@
module smct_alu #(
    parameter int VALUE_BITS = smct_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  op_div,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    output logic                  done,
    output logic [VALUE_BITS-1:0] result
);

    localparam int CNTW = $clog2(VALUE_BITS + 1);

    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] sh_reg, sh_next;
    logic [VALUE_BITS-1:0] opb_reg, opb_next;
    logic [VALUE_BITS-1:0] rem_sh;
    logic [VALUE_BITS-1:0] abs_a, abs_b;
    logic                  ge;

    assign abs_a  = a[VALUE_BITS-1] ? (~a + 1'b1) : a;
    assign abs_b  = b[VALUE_BITS-1] ? (~b + 1'b1) : b;
    assign rem_sh = {rem_reg[VALUE_BITS-2:0], sh_reg[VALUE_BITS-1]};
    assign ge     = (rem_sh >= opb_reg);

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        opb_next  = opb_reg;
        if (start)
        begin
            cnt_next  = CNTW'(VALUE_BITS);
            busy_next = 1'b1;
            div_next  = op_div;
            neg_next  = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
            acc_next  = '0;
            rem_next  = '0;
            sh_next   = op_div ? abs_a : a;
            opb_next  = op_div ? abs_b : b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            sh_next = {sh_reg[VALUE_BITS-2:0], 1'b0};
            if (div_reg)
            begin
                // restoring step, one quotient bit
                rem_next = ge ? (rem_sh - opb_reg) : rem_sh;
                acc_next = {acc_reg[VALUE_BITS-2:0], ge};
            end
            else
            begin
                // shift-add step, wraps to the value width
                acc_next = acc_reg + (opb_reg[0] ? sh_reg : '0);
                opb_next = {1'b0, opb_reg[VALUE_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        opb_reg <= opb_next;
    end

    assign done   = done_reg;
    assign result = (div_reg && neg_reg) ? (~acc_reg + 1'b1) : acc_reg;

endmodule

@@ hdl/smct_dp.sv @@
`include "sparse_matrix_coordinate_table_defines.svh"

module smct_dp #(
    parameter int ENTRIES    = smct_pkg::ENTRIES_DEF,
    parameter int INDEX_BITS = smct_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = smct_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smct_pkg::cmd_t        cmd,
    output smct_pkg::sts_t        sts,
    input  logic [1:0]            in_req_type,
    input  logic [INDEX_BITS-1:0] in_row,
    input  logic [INDEX_BITS-1:0] in_col,
    input  logic [VALUE_BITS-1:0] in_val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] out_value,
    output logic                  out_found,
    output logic [1:0]            out_status
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [INDEX_BITS-1:0] row_mem [0:ENTRIES-1];
    logic [INDEX_BITS-1:0] col_mem [0:ENTRIES-1];
    logic [VALUE_BITS-1:0] val_mem [0:ENTRIES-1];

    smct_pkg::req_t        req_reg;
    logic [INDEX_BITS-1:0] row_reg, col_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         count_reg;
    logic [INDEX_BITS-1:0] max_row_reg, max_col_reg;
    logic [AW-1:0]         idx_reg;
    logic                  more_reg, pend_reg, pend_last_reg;
    logic [INDEX_BITS-1:0] rd_row_reg, rd_col_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  res_found_reg;
    smct_pkg::status_t     res_status_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_found_reg;
    smct_pkg::status_t     out_status_reg;

    logic                  scan_rd, rd_en, full;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         count_m1;
    logic                  row_gt, col_gt;
    logic                  alu_done;
    logic [VALUE_BITS-1:0] alu_result;

    assign scan_rd  = cmd.scan && more_reg;
    assign rd_en    = scan_rd || cmd.scale_rd;
    assign rd_addr  = idx_reg;
    assign count_m1 = count_reg - CW'(1);
    assign full     = (count_reg == CW'(ENTRIES));
    assign row_gt   = $signed(row_reg) > $signed(max_row_reg);
    assign col_gt   = $signed(col_reg) > $signed(max_col_reg);

    smct_alu #(
        .VALUE_BITS (VALUE_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .op_div (req_reg == smct_pkg::REQ_DIV),
        .a      (rd_val_reg),
        .b      (val_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            row_mem[count_reg[AW-1:0]] <= row_reg;
            col_mem[count_reg[AW-1:0]] <= col_reg;
            val_mem[count_reg[AW-1:0]] <= val_reg;
        end
        else if (cmd.scale_wr)
        begin
            val_mem[idx_reg] <= alu_result;
        end
        if (rd_en)
        begin
            rd_row_reg <= row_mem[rd_addr];
            rd_col_reg <= col_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= smct_pkg::req_t'(in_req_type);
            row_reg <= in_row;
            col_reg <= in_col;
            val_reg <= in_val;
            res_value_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= smct_pkg::ST_OK;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.take_hit)
            begin
                res_value_reg <= rd_val_reg;
                res_found_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
            idx_reg       <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_entry)
            begin
                count_reg <= count_reg + CW'(1);
                if (row_gt)
                begin
                    max_row_reg <= row_reg;
                end
                if (col_gt)
                begin
                    max_col_reg <= col_reg;
                end
            end
            // newest entry first for lookups, oldest first for scaling
            if (cmd.scan_start)
            begin
                idx_reg  <= count_m1[AW-1:0];
                more_reg <= 1'b1;
            end
            else if (cmd.scale_start)
            begin
                idx_reg <= '0;
            end
            else if (scan_rd)
            begin
                idx_reg  <= idx_reg - 1'b1;
                more_reg <= (idx_reg != '0);
            end
            else if (cmd.scale_wr)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            pend_reg      <= scan_rd;
            pend_last_reg <= (idx_reg == '0);
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.req        = req_reg;
        sts.val_zero   = (val_reg == '0);
        sts.full       = full;
        sts.range_err  = row_reg[INDEX_BITS-1] || col_reg[INDEX_BITS-1] || row_gt || col_gt;
        sts.count_zero = (count_reg == '0);
        sts.hit        = pend_reg && (rd_row_reg == row_reg) && (rd_col_reg == col_reg);
        sts.scan_end   = pend_reg && pend_last_reg;
        sts.alu_done   = alu_done;
        sts.scale_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_found  = out_found_reg;
    assign out_status = out_status_reg;

    `SMCT_ASSERT_IMP(a_wr_not_full, clk, rst_n, cmd.wr_entry, !full, "entry write into a full table")
    `SMCT_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before transfer")
    `SMCT_ASSERT_IMP(a_wb_ready, clk, rst_n, cmd.scale_wr, alu_done, "scaled value written before arithmetic finished")
    `SMCT_ASSERT_NXT(a_count_bound, clk, rst_n, cmd.wr_entry, count_reg <= CW'(ENTRIES), "entry count beyond table depth")

endmodule

@@ hdl/smct_ctrl.sv @@
module smct_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  smct_pkg::sts_t sts,
    output smct_pkg::cmd_t cmd
);

    smct_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smct_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smct_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = smct_pkg::S_DECODE;
                end
            end
            smct_pkg::S_DECODE:
            begin
                case (sts.req)
                    smct_pkg::REQ_SET:
                    begin
                        state_next = smct_pkg::S_DONE;
                    end
                    smct_pkg::REQ_GET:
                    begin
                        if (sts.range_err || sts.count_zero)
                        begin
                            state_next = smct_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = smct_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        if ((sts.req == smct_pkg::REQ_DIV && sts.val_zero) || sts.count_zero)
                        begin
                            state_next = smct_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = smct_pkg::S_SC_RD;
                        end
                    end
                endcase
            end
            smct_pkg::S_SCAN:
            begin
                if (sts.hit || sts.scan_end)
                begin
                    state_next = smct_pkg::S_DONE;
                end
            end
            smct_pkg::S_SC_RD:
            begin
                state_next = smct_pkg::S_SC_LD;
            end
            smct_pkg::S_SC_LD:
            begin
                state_next = smct_pkg::S_SC_RUN;
            end
            smct_pkg::S_SC_RUN:
            begin
                if (sts.alu_done)
                begin
                    state_next = sts.scale_last ? smct_pkg::S_DONE : smct_pkg::S_SC_RD;
                end
            end
            smct_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = smct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smct_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd             = '0;
        cmd.status_code = smct_pkg::ST_OK;
        in_ready        = 1'b0;
        case (state_reg)
            smct_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            smct_pkg::S_DECODE:
            begin
                case (sts.req)
                    smct_pkg::REQ_SET:
                    begin
                        if (!sts.val_zero)
                        begin
                            if (sts.full)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = smct_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_entry = 1'b1;
                            end
                        end
                    end
                    smct_pkg::REQ_GET:
                    begin
                        if (sts.range_err)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = smct_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.scan_start = !sts.count_zero;
                        end
                    end
                    default:
                    begin
                        if (sts.req == smct_pkg::REQ_DIV && sts.val_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = smct_pkg::ST_DIV0;
                        end
                        else
                        begin
                            cmd.scale_start = !sts.count_zero;
                        end
                    end
                endcase
            end
            smct_pkg::S_SCAN:
            begin
                cmd.scan     = 1'b1;
                cmd.take_hit = sts.hit;
            end
            smct_pkg::S_SC_RD:
            begin
                cmd.scale_rd = 1'b1;
            end
            smct_pkg::S_SC_LD:
            begin
                cmd.alu_start = 1'b1;
            end
            smct_pkg::S_SC_RUN:
            begin
                cmd.scale_wr = sts.alu_done;
            end
            smct_pkg::S_DONE:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/sparse_matrix_coordinate_table.sv @@
// set and rejected requests pass from input transfer through decode to the result register,
// get compares one stored entry per cycle, newest first, until a hit or the last entry,
// multiply and divide rescale each stored entry in turn (bit-serial arithmetic unit)
// throughput: one request at a time, next input taken once the result is registered
// reset: control, entry count and row/column maxima cleared; entry store left as is
module sparse_matrix_coordinate_table #(
    parameter int ENTRIES    = smct_pkg::ENTRIES_DEF,
    parameter int INDEX_BITS = smct_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = smct_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    smct_in_if.sink     req,
    smct_out_if.source  rsp
);

    // command and status between sequencer and datapath
    smct_pkg::cmd_t cmd;
    smct_pkg::sts_t sts;

    // sequencer: decode, lookup scan, scale sweep, result hand-off
    smct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: entry memories, maxima, arithmetic unit, output register
    smct_dp #(
        .ENTRIES    (ENTRIES),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_req_type (req.req_type),
        .in_row      (req.row_index),
        .in_col      (req.col_index),
        .in_val      (req.operand_value),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_value   (rsp.read_value),
        .out_found   (rsp.found),
        .out_status  (rsp.status)
    );

endmodule
